/* rtl/abhs_pkg.sv */
package abhs_pkg;

    // Source word byte lanes (alpha in 31:24 is dropped)
    localparam int SumW     = 10;   // four bytes
    localparam int TotalW   = 12;   // sixteen bytes, max 4080

    localparam logic [1:0] LastQuad = 2'd3;

    // BT.601 studio range coefficients
    localparam int LumaR = 66;
    localparam int LumaG = 129;
    localparam int LumaB = 25;
    localparam int CbR   = 38;   // subtracted
    localparam int CbG   = 74;   // subtracted
    localparam int CbB   = 112;
    localparam int CrR   = 112;
    localparam int CrG   = 94;   // subtracted
    localparam int CrB   = 18;   // subtracted

    localparam int LumaOffset   = 16;
    localparam int ChromaOffset = 128;
    localparam int RoundHalf    = 128;

    typedef struct packed {
        logic [31:0] pixel_top_left;
        logic [31:0] pixel_top_right;
        logic [31:0] pixel_bottom_left;
        logic [31:0] pixel_bottom_right;
    } quad_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [1:0] quad_position;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       chroma_valid;
    } yuv_t;

    typedef struct packed {
        logic [SumW-1:0] red;
        logic [SumW-1:0] green;
        logic [SumW-1:0] blue;
    } chan_sum_t;

    typedef struct packed {
        logic [1:0] quad_position;
        logic [7:0] blue;
        logic [7:0] red;
        logic       valid;
    } chroma_t;

    function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
        logic [7:0] res;
        if (v < 12'sd0)
            res = 8'd0;
        else if (v > 12'sd255)
            res = 8'd255;
        else
            res = v[7:0];
        return res;
    endfunction

endpackage

/* rtl/abhs_quad_sum.sv */
module abhs_quad_sum (
    input  abhs_pkg::quad_t     quad,
    output abhs_pkg::chan_sum_t sums
);
    import abhs_pkg::*;

    logic [3:0][31:0] px;

    assign px = {quad.pixel_top_left, quad.pixel_top_right,
                 quad.pixel_bottom_left, quad.pixel_bottom_right};

    always_comb
    begin
        sums = '0;
        for (int i = 0; i < 4; i++)
        begin
            sums.red   = sums.red   + SumW'(px[i][7:0]);
            sums.green = sums.green + SumW'(px[i][15:8]);
            sums.blue  = sums.blue  + SumW'(px[i][23:16]);
        end
    end

endmodule

/* rtl/abhs_luma.sv */
module abhs_luma (
    input  abhs_pkg::chan_sum_t sums,
    output logic [7:0]          luma
);
    import abhs_pkg::*;

    logic [17:0]        weighted;
    logic [16:0]        rounded;
    logic signed [11:0] biased;

    always_comb
    begin
        weighted = 18'(LumaR * int'(sums.red)) + 18'(LumaG * int'(sums.green))
                 + 18'(LumaB * int'(sums.blue));
        // >>2 then round into the byte range
        rounded  = 17'(weighted[17:2]) + 17'(RoundHalf);
        biased   = 12'({3'b000, rounded[16:8]}) + 12'(LumaOffset);
        luma     = clamp_byte(biased);
    end

endmodule

/* rtl/abhs_chroma.sv */
module abhs_chroma (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  abhs_pkg::chan_sum_t sums,
    output abhs_pkg::chroma_t   chroma
);
    import abhs_pkg::*;

    logic [1:0]        pos_reg,   pos_next;
    logic [TotalW-1:0] red_reg,   red_next;
    logic [TotalW-1:0] green_reg, green_next;
    logic [TotalW-1:0] blue_reg,  blue_next;

    logic [TotalW-1:0]  rt, gt, bt;
    logic signed [21:0] u_acc, v_acc;
    logic signed [17:0] u_off, v_off;
    logic signed [9:0]  u_q, v_q;
    logic signed [11:0] cb_s, cr_s;
    logic               last;

    always_comb
    begin
        last = (pos_reg == LastQuad);
        rt   = red_reg   + TotalW'(sums.red);
        gt   = green_reg + TotalW'(sums.green);
        bt   = blue_reg  + TotalW'(sums.blue);

        u_acc = 22'(CbB * int'(bt) - CbR * int'(rt) - CbG * int'(gt));
        v_acc = 22'(CrR * int'(rt) - CrG * int'(gt) - CrB * int'(bt));

        // floor >>4, add half, floor >>8
        u_off = u_acc[21:4] + 18'sd128;
        v_off = v_acc[21:4] + 18'sd128;
        u_q   = u_off[17:8];
        v_q   = v_off[17:8];
        cb_s  = {{2{u_q[9]}}, u_q} + 12'(ChromaOffset);
        cr_s  = {{2{v_q[9]}}, v_q} + 12'(ChromaOffset);

        chroma.quad_position = pos_reg;
        chroma.valid         = last;
        chroma.blue          = last ? clamp_byte(cb_s) : 8'd0;
        chroma.red           = last ? clamp_byte(cr_s) : 8'd0;

        pos_next   = pos_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        if (step)
        begin
            pos_next   = pos_reg + 2'd1;
            red_next   = last ? '0 : rt;
            green_next = last ? '0 : gt;
            blue_next  = last ? '0 : bt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

/* rtl/abgr_half_scale_to_i420_top.sv */
// channel | valid      | ready      | word
// --------+------------+------------+---------------------------------------
// input   | quad_valid | quad_ready | quad : one 2x2 quad of ABGR pixels
// output  | yuv_valid  | yuv_ready  | yuv  : Y of the quad, Cb/Cr every 4th
//
// One word per cycle when both sides keep up; an accepted word passes through
// the input register, then the result register, which drives yuv.
// Quad counter and block totals step as a word moves into the result register.
// Reset clears the valid flags, the quad counter and the block totals.
// An output stall backs up into the input register; the input still takes
// a word whenever the input register is empty or drains in the same cycle.
module abgr_half_scale_to_i420_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            quad_valid,
    output logic            quad_ready,
    input  abhs_pkg::quad_t quad,
    output logic            yuv_valid,
    input  logic            yuv_ready,
    output abhs_pkg::yuv_t  yuv
);
    import abhs_pkg::*;

    quad_t     quad_reg,     quad_next;
    logic      quad_vld_reg, quad_vld_next;
    yuv_t      yuv_reg,      yuv_next;
    logic      yuv_vld_reg,  yuv_vld_next;

    chan_sum_t sums;
    logic [7:0] luma;
    chroma_t   chroma;
    logic      advance;

    // input register feeds the per-quad channel sums
    abhs_quad_sum u_sum (
        .quad (quad_reg),
        .sums (sums)
    );

    abhs_luma u_luma (
        .sums (sums),
        .luma (luma)
    );

    // block accumulator and Cb/Cr on the fourth quad
    abhs_chroma u_chroma (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sums   (sums),
        .chroma (chroma)
    );

    always_comb
    begin
        advance    = quad_vld_reg && (!yuv_vld_reg || yuv_ready);
        quad_ready = !quad_vld_reg || advance;

        quad_next     = quad_reg;
        quad_vld_next = quad_vld_reg;
        if (quad_ready)
        begin
            quad_next     = quad;
            quad_vld_next = quad_valid;
        end

        yuv_next     = yuv_reg;
        yuv_vld_next = yuv_vld_reg;
        if (advance)
        begin
            yuv_next.luma          = luma;
            yuv_next.quad_position = chroma.quad_position;
            yuv_next.chroma_blue   = chroma.blue;
            yuv_next.chroma_red    = chroma.red;
            yuv_next.chroma_valid  = chroma.valid;
            yuv_vld_next           = 1'b1;
        end
        else if (yuv_ready)
        begin
            yuv_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_vld_reg <= 1'b0;
            yuv_vld_reg  <= 1'b0;
        end
        else
        begin
            quad_vld_reg <= quad_vld_next;
            yuv_vld_reg  <= yuv_vld_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        quad_reg <= quad_next;
        yuv_reg  <= yuv_next;
    end

    assign yuv_valid = yuv_vld_reg;
    assign yuv       = yuv_reg;

`ifndef SYNTH
    // chroma flag goes with the last quad of the block, and only with it
    a_chroma_pos: assert property (@(posedge clk) disable iff (!rst_n)
        yuv_valid |-> (yuv.chroma_valid == (yuv.quad_position == LastQuad)))
        else $error("chroma flag does not match quad position");

    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (yuv_valid && !yuv.chroma_valid) |->
            (yuv.chroma_blue == 8'd0 && yuv.chroma_red == 8'd0))
        else $error("chroma bytes nonzero outside last quad");

    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        yuv_valid |-> (yuv.luma >= 8'd16 && yuv.luma <= 8'd235))
        else $error("luma outside studio range");

    // consecutive results step the quad position by one
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && yuv_vld_reg) |=>
            (yuv_reg.quad_position == $past(yuv_reg.quad_position) + 2'd1))
        else $error("quad position skipped");
`endif

endmodule
